[hdl/h2d_pkg.sv]
package h2d_pkg;

  // Operation carried in the input tuser field
  typedef enum logic [1:0] {
    OP_ADD       = 2'd0,
    OP_READ_GRID = 2'd1,
    OP_READ_X    = 2'd2,
    OP_READ_Y    = 2'd3
  } op_e;

  // Grid setup shared by the register file and the front end
  typedef struct packed {
    logic [15:0] x_low;      // Q3.12, two's complement
    logic [15:0] y_low;      // Q3.12, two's complement
    logic [15:0] bin_scale;  // Q8.8 bins per unit
    logic [14:0] slice_x;    // Q3.12 magnitude
    logic [14:0] slice_y;    // Q3.12 magnitude
  } cfg_t;

  // Bin index product keeps this many fraction bits
  localparam int unsigned SCALE_SHIFT = 20;

endpackage

[hdl/h2d_ram.sv]
module h2d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/h2d_queue.sv]
module h2d_queue #(
  parameter int unsigned WIDTH = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic [1:0]       count_q;
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Two-entry queue between front and back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

[hdl/h2d_front.sv]
module h2d_front import h2d_pkg::*; #(
  parameter int unsigned BINS = 256,
  localparam int unsigned IW = $clog2(BINS),
  localparam int unsigned ENTRY_W = 6 + 2 * IW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               en_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [15:0]        x_coord_i,
  input  logic [15:0]        y_coord_i,
  input  logic [7:0]         col_index_i,
  input  logic [7:0]         row_index_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output logic [ENTRY_W-1:0] q_data_o
);

  // Stage A registers
  logic        a_valid_q;
  logic [1:0]  a_op_q;
  logic [16:0] a_dx_q;
  logic [16:0] a_dy_q;
  logic        a_sx_q;
  logic        a_sy_q;
  logic [7:0]  a_col_q;
  logic [7:0]  a_row_q;

  logic [16:0] dx_d;
  logic [16:0] dy_d;
  logic [15:0] abs_x;
  logic [15:0] abs_y;

  // Offsets from the lower edges and slice tests
  assign dx_d  = {x_coord_i[15], x_coord_i} - {cfg_i.x_low[15], cfg_i.x_low};
  assign dy_d  = {y_coord_i[15], y_coord_i} - {cfg_i.y_low[15], cfg_i.y_low};
  assign abs_x = x_coord_i[15] ? (~x_coord_i + 16'd1) : x_coord_i;
  assign abs_y = y_coord_i[15] ? (~y_coord_i + 16'd1) : y_coord_i;

  assign in_ready_o = en_i && (!a_valid_q || q_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_op_q    <= OP_ADD;
      a_dx_q    <= '0;
      a_dy_q    <= '0;
      a_sx_q    <= 1'b0;
      a_sy_q    <= 1'b0;
      a_col_q   <= '0;
      a_row_q   <= '0;
    end else if (in_valid_i && in_ready_o) begin
      a_valid_q <= 1'b1;
      a_op_q    <= op_i;
      a_dx_q    <= dx_d;
      a_dy_q    <= dy_d;
      a_sx_q    <= (abs_x < {1'b0, cfg_i.slice_x});
      a_sy_q    <= (abs_y < {1'b0, cfg_i.slice_y});
      a_col_q   <= col_index_i;
      a_row_q   <= row_index_i;
    end else if (q_ready_i) begin
      a_valid_q <= 1'b0;
    end
  end

  // Stage B: scale offsets to bin numbers
  logic [31:0] mx;
  logic [31:0] my;
  logic [11:0] bx;
  logic [11:0] by;
  logic        x_in_add;
  logic        y_in_add;
  logic        col_ok;
  logic        row_ok;

  assign mx       = a_dx_q[15:0] * cfg_i.bin_scale;
  assign my       = a_dy_q[15:0] * cfg_i.bin_scale;
  assign bx       = mx[31:SCALE_SHIFT];
  assign by       = my[31:SCALE_SHIFT];
  assign x_in_add = !a_dx_q[16] && (bx < 12'(BINS));
  assign y_in_add = !a_dy_q[16] && (by < 12'(BINS));
  assign col_ok   = ({3'b000, a_col_q} < 11'(BINS));
  assign row_ok   = ({3'b000, a_row_q} < 11'(BINS));

  // Classify the word into store indexes and enables
  logic          e_sx;
  logic          e_sy;
  logic          e_xin;
  logic          e_yin;
  logic [IW-1:0] e_xi;
  logic [IW-1:0] e_yi;

  always_comb begin
    e_sx  = 1'b0;
    e_sy  = 1'b0;
    e_xin = 1'b0;
    e_yin = 1'b0;
    e_xi  = '0;
    e_yi  = '0;
    case (a_op_q)
      OP_ADD: begin
        e_sx  = a_sx_q;
        e_sy  = a_sy_q;
        e_xin = x_in_add;
        e_yin = y_in_add;
        e_xi  = x_in_add ? IW'(bx) : '0;
        e_yi  = y_in_add ? IW'(by) : '0;
      end
      OP_READ_GRID: begin
        e_xin = col_ok && row_ok;
        e_yin = col_ok && row_ok;
        e_xi  = (col_ok && row_ok) ? IW'(a_col_q) : '0;
        e_yi  = (col_ok && row_ok) ? IW'(a_row_q) : '0;
      end
      OP_READ_X: begin
        e_xin = col_ok;
        e_xi  = col_ok ? IW'(a_col_q) : '0;
      end
      OP_READ_Y: begin
        e_yin = col_ok;
        e_yi  = col_ok ? IW'(a_col_q) : '0;
      end
      default: begin
        e_xin = 1'b0;
      end
    endcase
  end

  assign q_valid_o = a_valid_q;
  assign q_data_o  = {a_op_q, e_sx, e_sy, e_xin, e_yin, e_xi, e_yi};

endmodule

[hdl/h2d_back.sv]
module h2d_back import h2d_pkg::*; #(
  parameter int unsigned BINS = 256,
  parameter int unsigned COUNT_BITS = 32,
  localparam int unsigned IW = $clog2(BINS),
  localparam int unsigned ENTRY_W = 6 + 2 * IW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               ready_o,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  logic [ENTRY_W-1:0] q_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        out_bin_o,
  output logic [31:0]        out_total_o,
  output logic               out_hit_o
);

  localparam int unsigned GD = BINS * BINS;
  localparam int unsigned AW = $clog2(GD);
  localparam logic [AW-1:0] CLR_LAST = AW'(GD - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_e;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

  // Unpack the queue head
  logic [1:0]    e_op;
  logic          e_sx;
  logic          e_sy;
  logic          e_xin;
  logic          e_yin;
  logic [IW-1:0] e_xi;
  logic [IW-1:0] e_yi;
  logic [AW-1:0] g_raddr;

  assign {e_op, e_sx, e_sy, e_xin, e_yin, e_xi, e_yi} = q_data_i;
  assign g_raddr = AW'(e_yi) * AW'(BINS) + AW'(e_xi);

  state_e                state_q;
  logic [AW-1:0]         clr_q;
  logic [1:0]            cur_op_q;
  logic                  cur_sx_q;
  logic                  cur_sy_q;
  logic                  cur_xin_q;
  logic                  cur_yin_q;
  logic [IW-1:0]         cur_xi_q;
  logic [IW-1:0]         cur_yi_q;
  logic [AW-1:0]         cur_gaddr_q;
  logic [COUNT_BITS-1:0] total_q;
  logic                  out_valid_q;
  logic [31:0]           out_bin_q;
  logic [31:0]           out_total_q;
  logic                  out_hit_q;

  logic                  pop;
  logic                  fire;
  logic                  clearing;
  logic                  clr_axis;
  logic [COUNT_BITS-1:0] g_rd;
  logic [COUNT_BITS-1:0] x_rd;
  logic [COUNT_BITS-1:0] y_rd;
  logic [COUNT_BITS-1:0] g_inc;
  logic                  hit;
  logic [COUNT_BITS-1:0] bin_d;
  logic [COUNT_BITS-1:0] total_d;

  assign clearing = (state_q == ST_CLEAR);
  assign clr_axis = clearing && (clr_q < AW'(BINS));
  assign pop      = (state_q == ST_IDLE) && q_valid_i;
  assign fire     = (state_q == ST_LOOK) && (!out_valid_q || out_ready_i);
  assign q_ready_o = (state_q == ST_IDLE);
  assign ready_o  = !clearing;

  // Update values and the result word
  always_comb begin
    g_inc   = sat_inc(g_rd);
    hit     = (cur_op_q == OP_ADD) && cur_xin_q && cur_yin_q;
    total_d = hit ? sat_inc(total_q) : total_q;
    case (cur_op_q)
      OP_ADD:       bin_d = hit ? g_inc : '0;
      OP_READ_GRID: bin_d = (cur_xin_q && cur_yin_q) ? g_rd : '0;
      OP_READ_X:    bin_d = cur_xin_q ? x_rd : '0;
      OP_READ_Y:    bin_d = cur_yin_q ? y_rd : '0;
      default:      bin_d = '0;
    endcase
  end

  // Write ports: zero sweep after reset, then increments
  logic                  g_we;
  logic                  x_we;
  logic                  y_we;
  logic [AW-1:0]         g_waddr;
  logic [IW-1:0]         x_waddr;
  logic [IW-1:0]         y_waddr;

  assign g_we    = clearing || (fire && hit);
  assign x_we    = clr_axis || (fire && (cur_op_q == OP_ADD) && cur_xin_q && cur_sy_q);
  assign y_we    = clr_axis || (fire && (cur_op_q == OP_ADD) && cur_yin_q && cur_sx_q);
  assign g_waddr = clearing ? clr_q : cur_gaddr_q;
  assign x_waddr = clearing ? clr_q[IW-1:0] : cur_xi_q;
  assign y_waddr = clearing ? clr_q[IW-1:0] : cur_yi_q;

  h2d_ram #(.WIDTH(COUNT_BITS), .DEPTH(GD)) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (clearing ? '0 : g_inc),
    .re_i    (pop),
    .raddr_i (g_raddr),
    .rdata_o (g_rd)
  );

  h2d_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_waddr),
    .wdata_i (clearing ? '0 : sat_inc(x_rd)),
    .re_i    (pop),
    .raddr_i (e_xi),
    .rdata_o (x_rd)
  );

  h2d_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (y_waddr),
    .wdata_i (clearing ? '0 : sat_inc(y_rd)),
    .re_i    (pop),
    .raddr_i (e_yi),
    .rdata_o (y_rd)
  );

  // Sequencer: clear sweep, fetch, update and hand off the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cur_op_q    <= OP_ADD;
      cur_sx_q    <= 1'b0;
      cur_sy_q    <= 1'b0;
      cur_xin_q   <= 1'b0;
      cur_yin_q   <= 1'b0;
      cur_xi_q    <= '0;
      cur_yi_q    <= '0;
      cur_gaddr_q <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_bin_q   <= '0;
      out_total_q <= '0;
      out_hit_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLR_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            cur_op_q    <= e_op;
            cur_sx_q    <= e_sx;
            cur_sy_q    <= e_sy;
            cur_xin_q   <= e_xin;
            cur_yin_q   <= e_yin;
            cur_xi_q    <= e_xi;
            cur_yi_q    <= e_yi;
            cur_gaddr_q <= g_raddr;
            state_q     <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (fire) begin
            total_q     <= total_d;
            out_valid_q <= 1'b1;
            out_bin_q   <= 32'(bin_d);
            out_total_q <= 32'(total_d);
            out_hit_q   <= hit;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bin_o   = out_bin_q;
  assign out_total_o = out_total_q;
  assign out_hit_o   = out_hit_q;

endmodule

[hdl/histogram_2d_with_axis_slices_top.sv]
// Two-dimensional histogram of Q3.12 sample points over a BINS x BINS grid, with an
// x-axis store fed by samples with |y| below slice_y and a y-axis store fed by samples
// with |x| below slice_x; all counters are COUNT_BITS wide and saturate. Each word
// carries an operation in tuser: add a sample (result gives the new 2D bin count, the
// running in-grid total and an in-grid flag) or read one bin of one store (result gives
// that count and the total). After reset the block sweeps all three stores to zero,
// one grid entry per cycle, so no word is taken until the sweep ends; configuration
// writes are taken during that sweep. A two-stage front end scales coordinates to
// bin numbers and feeds a two-entry queue; the back end handles each word as a
// registered RAM read, then the update write and the result, and takes no new word
// until it is through with the last, as set by the read-modify-write on the grid RAM.
// A result word passes the stage A register, the queue, the back end's registered
// RAM read and its result register in turn.
module histogram_2d_with_axis_slices_top import h2d_pkg::*; #(
  parameter int unsigned BINS = 256,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // x_coord[15:0], y_coord[31:16],
                                        // col_index[39:32], row_index[47:40]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // bin_count[31:0], total_count[63:32]
  output logic [0:0]  m_axis_tuser_o    // in_grid[0]
);

  localparam int unsigned IW = $clog2(BINS);
  localparam int unsigned ENTRY_W = 6 + 2 * IW;

  localparam logic [2:0] REG_X_LOW     = 3'd0;
  localparam logic [2:0] REG_Y_LOW     = 3'd1;
  localparam logic [2:0] REG_BIN_SCALE = 3'd2;
  localparam logic [2:0] REG_SLICE_X   = 3'd3;
  localparam logic [2:0] REG_SLICE_Y   = 3'd4;

  localparam logic [15:0] LOW_RST   = 16'hB000;  // minus five
  localparam logic [15:0] SCALE_RST = 16'd6554;
  localparam logic [14:0] SLICE_RST = 15'd160;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_low     <= LOW_RST;
      cfg_q.y_low     <= LOW_RST;
      cfg_q.bin_scale <= SCALE_RST;
      cfg_q.slice_x   <= SLICE_RST;
      cfg_q.slice_y   <= SLICE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_X_LOW:     cfg_q.x_low     <= cfg_data_i;
        REG_Y_LOW:     cfg_q.y_low     <= cfg_data_i;
        REG_BIN_SCALE: cfg_q.bin_scale <= cfg_data_i;
        REG_SLICE_X:   cfg_q.slice_x   <= cfg_data_i[14:0];
        REG_SLICE_Y:   cfg_q.slice_y   <= cfg_data_i[14:0];
        default:       cfg_q.x_low     <= cfg_q.x_low;
      endcase
    end
  end

  logic               back_ready;
  logic               fq_valid;
  logic               fq_ready;
  logic [ENTRY_W-1:0] fq_data;
  logic               qb_valid;
  logic               qb_ready;
  logic [ENTRY_W-1:0] qb_data;
  logic [31:0]        out_bin;
  logic [31:0]        out_total;
  logic               out_hit;

  h2d_front #(.BINS(BINS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .en_i        (back_ready),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .op_i        (s_axis_tuser_i),
    .x_coord_i   (s_axis_tdata_i[15:0]),
    .y_coord_i   (s_axis_tdata_i[31:16]),
    .col_index_i (s_axis_tdata_i[39:32]),
    .row_index_i (s_axis_tdata_i[47:40]),
    .q_valid_o   (fq_valid),
    .q_ready_i   (fq_ready),
    .q_data_o    (fq_data)
  );

  h2d_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_data),
    .out_valid_o (qb_valid),
    .out_ready_i (qb_ready),
    .out_data_o  (qb_data)
  );

  h2d_back #(.BINS(BINS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ready_o     (back_ready),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_data_i    (qb_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_bin_o   (out_bin),
    .out_total_o (out_total),
    .out_hit_o   (out_hit)
  );

  assign m_axis_tdata_o = {out_total, out_bin};
  assign m_axis_tuser_o = out_hit;

endmodule

[bench/histogram_2d_with_axis_slices_checker.sv]
package h2d_bench_pkg;
  import h2d_pkg::*;

  // Register indexes of the setup channel; the spare index is not decoded
  typedef enum logic [2:0] {
    REG_X_LOW     = 3'd0,
    REG_Y_LOW     = 3'd1,
    REG_BIN_SCALE = 3'd2,
    REG_SLICE_X   = 3'd3,
    REG_SLICE_Y   = 3'd4,
    REG_SPARE     = 3'd7
  } reg_e;

  // One result word as it leaves the block
  typedef struct packed {
    logic [31:0] bin_count;
    logic [31:0] total_count;
    logic        in_grid;
  } tally_t;

  // Grid setup after reset: edges at -5, 256 bins over 10 units, slices of 160 LSB
  localparam cfg_t RESET_SETUP = '{x_low: 16'hB000, y_low: 16'hB000, bin_scale: 16'd6554,
                                   slice_x: 15'd160, slice_y: 15'd160};
endpackage

module histogram_2d_with_axis_slices_checker import h2d_pkg::*, h2d_bench_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,   // x_coord, y_coord, col_index, row_index
  input  logic [1:0]  s_tuser_i,   // op
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,   // bin_count, total_count
  input  logic [0:0]  m_tuser_i,   // in_grid
  output int unsigned tallies_due_o,
  output int          fail_count_o,
  output int          samples_o,
  output int          hits_o,
  output int          reads_o
);

  // Shadow of the block: setup, the three stores and the in-grid total
  cfg_t        setup;
  bit   [31:0] grid_cnt  [65536];
  bit   [31:0] xaxis_cnt [256];
  bit   [31:0] yaxis_cnt [256];
  bit   [31:0] grid_total;

  tally_t due_tallies [$];
  tally_t want;
  int     fails;
  int     samples;
  int     hits;
  int     reads;

  function automatic logic [31:0] bump(input logic [31:0] cnt);
    return (cnt == '1) ? cnt : cnt + 32'd1;
  endfunction

  // Map a coordinate to its bin; low edge inclusive, upper edge exclusive
  function automatic logic lands_in(input logic [15:0] v, input logic [15:0] low,
                                    output logic [7:0] bin);
    logic signed [16:0] diff;
    logic        [31:0] prod;
    bin  = '0;
    diff = $signed({v[15], v}) - $signed({low[15], low});
    if (diff < 0) return 1'b0;
    prod = diff[15:0] * setup.bin_scale;
    if (prod[31:28] != '0) return 1'b0;
    bin = prod[27:20];
    return 1'b1;
  endfunction

  // Apply one input word to the shadow stores and build its result
  function automatic tally_t tally_word(input op_e op, input logic [15:0] x_coord,
                                        input logic [15:0] y_coord,
                                        input logic [7:0] col, input logic [7:0] row);
    tally_t      res;
    logic        x_in;
    logic        y_in;
    logic [7:0]  x_bin;
    logic [7:0]  y_bin;
    logic [16:0] x_mag;
    logic [16:0] y_mag;
    res = '0;
    case (op)
      OP_ADD: begin
        x_in  = lands_in(x_coord, setup.x_low, x_bin);
        y_in  = lands_in(y_coord, setup.y_low, y_bin);
        x_mag = x_coord[15] ? 17'd0 - {1'b1, x_coord} : {1'b0, x_coord};
        y_mag = y_coord[15] ? 17'd0 - {1'b1, y_coord} : {1'b0, y_coord};
        if (x_in && y_in) begin
          grid_cnt[{y_bin, x_bin}] = bump(grid_cnt[{y_bin, x_bin}]);
          res.bin_count = grid_cnt[{y_bin, x_bin}];
          grid_total    = bump(grid_total);
          res.in_grid   = 1'b1;
        end
        if (x_mag < setup.slice_x && y_in) yaxis_cnt[y_bin] = bump(yaxis_cnt[y_bin]);
        if (y_mag < setup.slice_y && x_in) xaxis_cnt[x_bin] = bump(xaxis_cnt[x_bin]);
      end
      OP_READ_GRID: res.bin_count = grid_cnt[{row, col}];
      OP_READ_X:    res.bin_count = xaxis_cnt[col];
      OP_READ_Y:    res.bin_count = yaxis_cnt[col];
      default: ;
    endcase
    res.total_count = grid_total;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup      = RESET_SETUP;
      grid_total = '0;
      foreach (grid_cnt[i]) grid_cnt[i] = '0;
      foreach (xaxis_cnt[i]) begin
        xaxis_cnt[i] = '0;
        yaxis_cnt[i] = '0;
      end
      due_tallies.delete();
      fails   = 0;
      samples = 0;
      hits    = 0;
      reads   = 0;
    end else begin
      // Track setup writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_X_LOW:     setup.x_low     = cfg_data_i;
          REG_Y_LOW:     setup.y_low     = cfg_data_i;
          REG_BIN_SCALE: setup.bin_scale = cfg_data_i;
          REG_SLICE_X:   setup.slice_x   = cfg_data_i[14:0];
          REG_SLICE_Y:   setup.slice_y   = cfg_data_i[14:0];
          default: ;
        endcase
      end

      // Predict each accepted input word
      if (s_tvalid_i && s_tready_i) begin
        want = tally_word(op_e'(s_tuser_i), s_tdata_i[15:0], s_tdata_i[31:16],
                          s_tdata_i[39:32], s_tdata_i[47:40]);
        due_tallies.push_back(want);
        if (op_e'(s_tuser_i) == OP_ADD) begin
          samples++;
          hits += want.in_grid;
        end else begin
          reads++;
        end
      end

      // Compare each result word with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (due_tallies.size() == 0) begin
          fails++;
          $display("%0t: result word, expected none, got bin %0d total %0d in_grid %0b",
                   $time, m_tdata_i[31:0], m_tdata_i[63:32], m_tuser_i[0]);
        end else begin
          want = due_tallies.pop_front();
          check_field("bin_count", want.bin_count, m_tdata_i[31:0]);
          check_field("total_count", want.total_count, m_tdata_i[63:32]);
          check_field("in_grid", 32'(want.in_grid), 32'(m_tuser_i[0]));
        end
      end
    end

    tallies_due_o <= due_tallies.size();
    fail_count_o  <= fails;
    samples_o     <= samples;
    hits_o        <= hits;
    reads_o       <= reads;
  end

endmodule

[bench/histogram_2d_with_axis_slices_top_test.sv]
module histogram_2d_with_axis_slices_top_test;
  import h2d_pkg::*;
  import h2d_bench_pkg::*;

  // The idle limit must cover the post-reset sweep, which alone keeps every channel quiet
  localparam int unsigned IDLE_LIMIT   = 262144;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  int unsigned tallies_due;
  int          fail_count;
  int          samples_seen;
  int          hits_seen;
  int          reads_seen;

  int unsigned stall_left   = 0;
  logic        rx_stalls_on = 1'b0;
  logic        tx_gaps_on   = 1'b0;
  int unsigned idle_cycles  = 0;
  int          setups_run   = 1;
  cfg_t        cur          = RESET_SETUP;
  cfg_t        wild;
  logic [7:0]  pool_col [6];
  logic [7:0]  pool_row [6];

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  histogram_2d_with_axis_slices_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  histogram_2d_with_axis_slices_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .tallies_due_o (tallies_due),
    .fail_count_o  (fail_count),
    .samples_o     (samples_seen),
    .hits_o        (hits_seen),
    .reads_o       (reads_seen)
  );

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coordinate near the middle of a bin, jittered within the bin
  function automatic logic [15:0] bin_coord(input logic [15:0] low, input logic [15:0] scale,
                                            input logic [7:0] bin);
    longint span;
    longint c;
    if (scale == '0) return low + 16'($urandom_range(0, 4095));
    span = (longint'(1) << 20) / longint'(scale);
    c    = longint'($signed(low)) + ((2 * longint'(bin) + 1) << 19) / longint'(scale);
    c    = c + longint'($urandom_range(0, int'(span / 2))) - span / 4;
    return c[15:0];
  endfunction

  // Coordinate on or just past either grid edge
  function automatic logic [15:0] edge_coord(input logic [15:0] low, input logic [15:0] scale);
    longint first_out;
    longint c;
    first_out = (scale == '0) ? 65536 :
                ((longint'(256) << 20) + longint'(scale) - 1) / longint'(scale);
    case ($urandom_range(0, 3))
      0:       c = longint'($signed(low));
      1:       c = longint'($signed(low)) - 1;
      2:       c = longint'($signed(low)) + first_out - 1;
      default: c = longint'($signed(low)) + first_out;
    endcase
    return c[15:0];
  endfunction

  // Coordinate within one LSB of the slice band or inside it
  function automatic logic [15:0] slice_coord(input logic [14:0] slice);
    int v;
    v = int'($urandom_range(0, 2 * int'(slice) + 2)) - (int'(slice) + 1);
    return v[15:0];
  endfunction

  // Hold valid high until the setup word is taken
  task automatic write_reg(input reg_e idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_setup(input cfg_t c);
    write_reg(REG_X_LOW, c.x_low);
    write_reg(REG_Y_LOW, c.y_low);
    write_reg(REG_BIN_SCALE, c.bin_scale);
    write_reg(REG_SLICE_X, {1'($urandom), c.slice_x});
    write_reg(REG_SLICE_Y, {1'($urandom), c.slice_y});
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
    cur = c;
  endtask

  // Offer one word, after an optional gap, and wait until it is taken
  task automatic send_word(input op_e op, input logic [15:0] x_coord,
                           input logic [15:0] y_coord,
                           input logic [7:0] col, input logic [7:0] row);
    int unsigned gap;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {row, col, y_coord, x_coord};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly samples aimed at a few busy bins, slice bands and edges; some noise and reads
  task automatic random_item();
    op_e         op;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [7:0]  col;
    logic [7:0]  row;
    int unsigned pick;
    int unsigned r;
    pick    = $urandom_range(0, 5);
    col     = pool_col[pick];
    row     = pool_row[pick];
    x_coord = 16'($urandom);
    y_coord = 16'($urandom);
    if ($urandom_range(0, 99) < 35) begin
      op = op_e'($urandom_range(1, 3));
      if ($urandom_range(0, 9) < 3) begin
        col = 8'($urandom);
        row = 8'($urandom);
      end
    end else begin
      op = OP_ADD;
      r  = $urandom_range(0, 99);
      if (r < 45) begin
        x_coord = bin_coord(cur.x_low, cur.bin_scale, col);
        y_coord = bin_coord(cur.y_low, cur.bin_scale, row);
      end else if (r < 55) begin
        x_coord = slice_coord(cur.slice_x);
        y_coord = bin_coord(cur.y_low, cur.bin_scale, row);
      end else if (r < 65) begin
        x_coord = bin_coord(cur.x_low, cur.bin_scale, col);
        y_coord = slice_coord(cur.slice_y);
      end else if (r < 80) begin
        x_coord = edge_coord(cur.x_low, cur.bin_scale);
        y_coord = $urandom_range(0, 1) ? edge_coord(cur.y_low, cur.bin_scale)
                                       : bin_coord(cur.y_low, cur.bin_scale, row);
      end
      col = 8'($urandom);
      row = 8'($urandom);
    end
    send_word(op, x_coord, y_coord, col, row);
  endtask

  // Drain, load a new setup, then stream random words with changing idle patterns
  task automatic run_phase(input cfg_t c, input int unsigned n);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tallies_due != 0) @(posedge clk);
    write_setup(c);
    setups_run++;
    foreach (pool_col[k]) begin
      pool_col[k] = 8'($urandom);
      pool_row[k] = 8'($urandom);
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_gaps_on    = ($urandom_range(0, 2) != 0);
        rx_stalls_on <= ($urandom_range(0, 2) != 0);
      end
      random_item();
    end
  endtask

  // Result side: random stalls while enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (rx_stalls_on) stall_left <= idle_len();
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("[histogram_2d_with_axis_slices_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n        <= 1'b1;
    rx_stalls_on <= 1'b1;
    tx_gaps_on    = 1'b1;

    // Directed words at the reset setup: edges, slice bands, extremes, every read
    send_word(OP_ADD, 16'sd0, 16'sd0, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd0, 16'sd0, 8'd255, 8'd255);
    send_word(OP_ADD, -16'sd20480, 16'sd0, 8'd0, 8'd0);
    send_word(OP_ADD, -16'sd20481, 16'sd0, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd20477, 16'sd20477, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd20478, 16'sd0, 8'd0, 8'd0);
    send_word(OP_ADD, 16'h8000, 16'h8000, 8'd0, 8'd0);
    send_word(OP_ADD, 16'h7FFF, 16'h7FFF, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd159, -16'sd159, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd160, -16'sd160, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd0, 16'sd30000, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd5000, 16'sd100, 8'd0, 8'd0);
    send_word(OP_ADD, 16'sd100, -16'sd5000, 8'd0, 8'd0);
    send_word(OP_READ_GRID, 16'h0000, 16'h0000, 8'd128, 8'd128);
    send_word(OP_READ_X, 16'hFFFF, 16'hFFFF, 8'd128, 8'd255);
    send_word(OP_READ_Y, 16'h0000, 16'h0000, 8'd128, 8'd0);
    send_word(OP_READ_GRID, 16'h0000, 16'h0000, 8'd0, 8'd0);
    send_word(OP_READ_GRID, 16'h0000, 16'h0000, 8'd255, 8'd255);
    send_word(OP_READ_X, 16'h0000, 16'h0000, 8'd255, 8'd0);
    send_word(OP_READ_Y, 16'h0000, 16'h0000, 8'd0, 8'd255);
    send_word(OP_READ_X, 16'h0000, 16'h0000, 8'd159, 8'd0);
    send_word(OP_READ_Y, 16'h0000, 16'h0000, 8'd96, 8'd0);
    send_word(OP_READ_GRID, 16'hFFFF, 16'hFFFF, 8'd128, 8'd255);

    // Full-range grid, widest slices
    run_phase(cfg_t'{x_low: 16'h8000, y_low: 16'h8000, bin_scale: 16'd4096,
                     slice_x: 15'h7FFF, slice_y: 15'h7FFF}, 150);
    // Top x edge, finest bins, closed slices
    run_phase(cfg_t'{x_low: 16'h7FFF, y_low: 16'h8000, bin_scale: 16'hFFFF,
                     slice_x: 15'd0, slice_y: 15'd0}, 60);
    // Zero scale: everything at or above the low edge lands in bin zero
    run_phase(cfg_t'{x_low: 16'h0000, y_low: 16'hF000, bin_scale: 16'd0,
                     slice_x: 15'd4096, slice_y: 15'd300}, 50);
    // Coarsest nonzero scale
    run_phase(cfg_t'{x_low: 16'hC000, y_low: 16'h8000, bin_scale: 16'd1,
                     slice_x: 15'd1, slice_y: 15'd2000}, 40);
    run_phase(RESET_SETUP, 150);
    wild.x_low     = 16'(-int'($urandom_range(2048, 24576)));
    wild.y_low     = 16'(-int'($urandom_range(2048, 24576)));
    wild.bin_scale = 16'($urandom_range(2000, 20000));
    wild.slice_x   = 15'($urandom_range(0, 8192));
    wild.slice_y   = 15'($urandom_range(0, 8192));
    run_phase(wild, 100);

    // Drain and let the pipeline settle
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tallies_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples (%0d inside the grid) and %0d bin reads over %0d setups,",
             samples_seen, hits_seen, reads_seen, setups_run);
    $display("with edge offsets, zero and unit scale, closed and full slices, random stalls.");
    if (fail_count == 0 && tallies_due == 0) begin
      $display("[histogram_2d_with_axis_slices_top] OK");
    end else begin
      $display("[histogram_2d_with_axis_slices_top] ERROR");
    end
    $finish;
  end

endmodule
